FILE: rtl/core/lodm_pkg.sv
package lodm_pkg;

   // Raw fault flags carried by one status sample
   localparam int NUM_FLAGS = 7;
   localparam int CNT_W     = 8;

   // Flag positions inside the debounced flag vector
   localparam int FLAG_POS_OVER   = 0;
   localparam int FLAG_POS_UNDER  = 1;
   localparam int FLAG_NEG_OVER   = 2;
   localparam int FLAG_NEG_UNDER  = 3;
   localparam int FLAG_DRIVE      = 4;
   localparam int FLAG_LVL_OVER   = 5;
   localparam int FLAG_LVL_UNDER  = 6;

   // Electrode bits of the disconnect masks
   localparam int MASK_DRIVE_POS = 0;
   localparam int MASK_SENSE_POS = 1;
   localparam int MASK_SENSE_NEG = 2;
   localparam int MASK_DRIVE_NEG = 3;

   localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 8'd3;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 32;

   typedef enum logic [1:0] {
      CONF_CONNECTED    = 2'd0,
      CONF_DEFINITE_OFF = 2'd1,
      CONF_PROBABLE_OFF = 2'd2,
      CONF_AMBIGUOUS    = 2'd3
   } conf_type;

   typedef struct packed {
      logic                 measuring;
      logic                 monitor_enable;
      logic [NUM_FLAGS-1:0] raw_flags;
   } sample_type;

   typedef struct packed {
      conf_type             drive_neg_confidence;
      conf_type             sense_neg_confidence;
      conf_type             sense_pos_confidence;
      conf_type             drive_pos_confidence;
      logic [3:0]           possible_off_mask;
      logic [3:0]           off_mask;
      logic                 compliance_warning;
      logic                 drive_leads_invalid;
      logic                 neg_sense_off;
      logic                 pos_sense_off;
      logic [NUM_FLAGS-1:0] debounced_flags;
      logic                 active;
   } result_type;

endpackage

FILE: rtl/core/lead_off_debounce_monitor.sv
// Lead-off debounce monitor. Each req item is one polled status sample: seven
// raw fault flags (tdata bits 6:0) plus monitor_enable (bit 7) and measuring
// (bit 8). While enabled and measuring, each flag runs an 8-bit saturating
// counter that clears when the flag is low; a flag is debounced once its
// counter reaches csr_debounce_count (reset 3, zero makes every flag debounced).
// Every sample gives exactly one rsp item with the debounced flags, electrode
// off flags, masks and confidence codes; an inactive sample clears all
// counters and returns an all-zero item. Each sample passes through the sample
// register, then the result register; one sample is taken every cycle, limited
// only by backpressure on rsp. Write csr only while no item is in flight.
module lead_off_debounce_monitor (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [lodm_pkg::CNT_W-1:0]      csr_debounce_count,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [0] sense_pos_over [1] sense_pos_under [2] sense_neg_over
   // [3] sense_neg_under [4] drive_out_of_range [5] level_over
   // [6] level_under [7] monitor_enable [8] measuring, rest zero
   input  logic [lodm_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] active [7:1] debounced_flags [8] pos_sense_off [9] neg_sense_off
   // [10] drive_leads_invalid [11] compliance_warning [15:12] off_mask
   // [19:16] possible_off_mask [21:20] drive_pos_confidence
   // [23:22] sense_pos_confidence [25:24] sense_neg_confidence
   // [27:26] drive_neg_confidence, rest zero
   output logic [lodm_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int CW        = lodm_pkg::CNT_W;
   localparam int NUM_FLAGS = lodm_pkg::NUM_FLAGS;

   logic [CW-1:0]          debounce_ff, debounce_in;
   logic                   smp_valid_ff, smp_valid_in;
   lodm_pkg::sample_type   smp_ff, smp_in;
   logic                   out_valid_ff, out_valid_in;
   lodm_pkg::result_type   out_ff, out_in;
   logic [CW-1:0]          cnt_ff [NUM_FLAGS];
   logic [CW-1:0]          cnt_in [NUM_FLAGS];
   logic                   advance;
   logic                   run;
   logic [NUM_FLAGS-1:0]   deb;
   logic                   pos_off, neg_off, drv, ac_off, invalid;

   // Handshake: sample stage moves on whenever the result register is empty or being read out
   assign advance    = smp_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !smp_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(lodm_pkg::RSP_DATA_W - $bits(lodm_pkg::result_type)){1'b0}},
                        out_ff};

   // Config register
   assign debounce_in = csr_we ? csr_debounce_count : debounce_ff;

   // Sample register
   always_comb begin
      smp_valid_in = smp_valid_ff;
      smp_in       = smp_ff;
      if (advance) begin
         smp_valid_in = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         smp_valid_in = 1'b1;
         smp_in       = req_tdata[$bits(lodm_pkg::sample_type)-1:0];
      end
   end

   // Counter update and debounce compare
   assign run = smp_ff.monitor_enable && smp_ff.measuring;

   always_comb begin
      for (int i = 0; i < NUM_FLAGS; i++) begin
         cnt_in[i] = cnt_ff[i];
         if (advance) begin
            if (!run || !smp_ff.raw_flags[i]) begin
               cnt_in[i] = '0;
            end else if (cnt_ff[i] < debounce_ff) begin
               cnt_in[i] = cnt_ff[i] + CW'(1);
            end
         end
         deb[i] = run && (cnt_in[i] >= debounce_ff);
      end
   end

   // Derived electrode status
   assign pos_off = deb[lodm_pkg::FLAG_POS_OVER] || deb[lodm_pkg::FLAG_POS_UNDER];
   assign neg_off = deb[lodm_pkg::FLAG_NEG_OVER] || deb[lodm_pkg::FLAG_NEG_UNDER];
   assign drv     = deb[lodm_pkg::FLAG_DRIVE];
   assign ac_off  = deb[lodm_pkg::FLAG_LVL_OVER] || deb[lodm_pkg::FLAG_LVL_UNDER];
   assign invalid = ac_off && (!(pos_off || neg_off) || drv);

   always_comb begin
      out_in                      = '0;
      out_in.active               = run;
      out_in.debounced_flags      = deb;
      out_in.pos_sense_off        = pos_off;
      out_in.neg_sense_off        = neg_off;
      out_in.drive_leads_invalid  = invalid;
      out_in.compliance_warning   = drv && !ac_off;
      out_in.off_mask[lodm_pkg::MASK_SENSE_POS]          = pos_off;
      out_in.off_mask[lodm_pkg::MASK_SENSE_NEG]          = neg_off;
      out_in.possible_off_mask[lodm_pkg::MASK_SENSE_POS] = pos_off;
      out_in.possible_off_mask[lodm_pkg::MASK_SENSE_NEG] = neg_off;
      out_in.possible_off_mask[lodm_pkg::MASK_DRIVE_POS] = invalid;
      out_in.possible_off_mask[lodm_pkg::MASK_DRIVE_NEG] = invalid;
      out_in.drive_pos_confidence = invalid ? lodm_pkg::CONF_AMBIGUOUS
                                            : lodm_pkg::CONF_CONNECTED;
      out_in.drive_neg_confidence = out_in.drive_pos_confidence;
      out_in.sense_pos_confidence = pos_off ? lodm_pkg::CONF_DEFINITE_OFF
                                            : lodm_pkg::CONF_CONNECTED;
      out_in.sense_neg_confidence = neg_off ? lodm_pkg::CONF_DEFINITE_OFF
                                            : lodm_pkg::CONF_CONNECTED;
      if (!advance) begin
         out_in = out_ff;
      end
   end

   // Result register valid
   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff  <= lodm_pkg::DEBOUNCE_RESET;
         smp_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_FLAGS; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         debounce_ff  <= debounce_in;
         smp_valid_ff <= smp_valid_in;
         out_valid_ff <= out_valid_in;
         for (int i = 0; i < NUM_FLAGS; i++) begin
            cnt_ff[i] <= cnt_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      smp_ff <= smp_in;
      out_ff <= out_in;
   end

   // An inactive result carries nothing but zeros
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.active |-> out_ff == '0)
      else $error("inactive result has nonzero fields");

   // Definite mask never marks drive electrodes
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !out_ff.off_mask[lodm_pkg::MASK_DRIVE_POS]
                    && !out_ff.off_mask[lodm_pkg::MASK_DRIVE_NEG])
      else $error("drive bit set in definite off mask");

   // A held sample is not dropped
   assert property (@(posedge clock) disable iff (reset)
      smp_valid_ff && !advance |=> smp_valid_ff && $stable(smp_ff))
      else $error("stalled sample lost");

   // A stalled result is not overwritten
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready |=> out_valid_ff && $stable(out_ff))
      else $error("stalled result overwritten");

   // First and last counters start cleared after reset
   assert property (@(posedge clock)
      reset |=> cnt_ff[0] == '0 && cnt_ff[NUM_FLAGS-1] == '0)
      else $error("counters not cleared by reset");

endmodule

FILE: tb/lead_off_debounce_monitor_tb.sv
`timescale 1ns / 1ps

module lead_off_debounce_monitor_tb;

   localparam int          NUM_FLAGS    = lodm_pkg::NUM_FLAGS;
   localparam int          CNT_W        = lodm_pkg::CNT_W;
   localparam int          REQ_DATA_W   = lodm_pkg::REQ_DATA_W;
   localparam int          RSP_DATA_W   = lodm_pkg::RSP_DATA_W;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned REPORT_LIMIT = 10;
   localparam int unsigned SAMPLE_W     = $bits(lodm_pkg::sample_type);
   localparam int unsigned STATUS_W     = $bits(lodm_pkg::result_type);
   localparam logic [NUM_FLAGS-1:0] ALL_FLAGS = '1;

   typedef enum int unsigned {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_PULSED
   } ready_pattern_type;

   // Debounce predictor and store of expected status items
   class debounce_tracker_type;
      logic [CNT_W-1:0]     debounce_count = lodm_pkg::DEBOUNCE_RESET;
      logic [CNT_W-1:0]     run_count [NUM_FLAGS];
      lodm_pkg::result_type status_q [$];
      int unsigned          mismatches = 0;

      function new();
         foreach (run_count[i]) run_count[i] = '0;
      endfunction

      function void set_count(logic [CNT_W-1:0] value);
         debounce_count = value;
      endfunction

      // Advance the flag counters for one accepted sample, queue its status
      function void note_sample(lodm_pkg::sample_type s);
         lodm_pkg::result_type st;
         logic [NUM_FLAGS-1:0] deb;
         logic                 pos_off, neg_off, drv, ac_off, invalid;
         int                   i;
         st = '0;
         if (!(s.monitor_enable && s.measuring)) begin
            // inactive sample: all counters cleared, all-zero status
            foreach (run_count[j]) run_count[j] = '0;
         end else begin
            deb = '0;
            for (i = 0; i < NUM_FLAGS; i++) begin
               if (s.raw_flags[i]) begin
                  if (run_count[i] < debounce_count) run_count[i]++;
               end else begin
                  run_count[i] = '0;
               end
               // a count of zero makes every flag debounced
               deb[i] = (run_count[i] >= debounce_count);
            end
            pos_off = deb[lodm_pkg::FLAG_POS_OVER] | deb[lodm_pkg::FLAG_POS_UNDER];
            neg_off = deb[lodm_pkg::FLAG_NEG_OVER] | deb[lodm_pkg::FLAG_NEG_UNDER];
            drv     = deb[lodm_pkg::FLAG_DRIVE];
            ac_off  = deb[lodm_pkg::FLAG_LVL_OVER] | deb[lodm_pkg::FLAG_LVL_UNDER];
            invalid = ac_off && (!(pos_off || neg_off) || drv);

            st.active                                     = 1'b1;
            st.debounced_flags                            = deb;
            st.pos_sense_off                              = pos_off;
            st.neg_sense_off                              = neg_off;
            st.drive_leads_invalid                        = invalid;
            st.compliance_warning                         = drv && !ac_off;
            st.off_mask[lodm_pkg::MASK_SENSE_POS]         = pos_off;
            st.off_mask[lodm_pkg::MASK_SENSE_NEG]         = neg_off;
            st.possible_off_mask                          = st.off_mask;
            st.possible_off_mask[lodm_pkg::MASK_DRIVE_POS] = invalid;
            st.possible_off_mask[lodm_pkg::MASK_DRIVE_NEG] = invalid;
            st.drive_pos_confidence = invalid ? lodm_pkg::CONF_AMBIGUOUS
                                              : lodm_pkg::CONF_CONNECTED;
            st.drive_neg_confidence = invalid ? lodm_pkg::CONF_AMBIGUOUS
                                              : lodm_pkg::CONF_CONNECTED;
            st.sense_pos_confidence = pos_off ? lodm_pkg::CONF_DEFINITE_OFF
                                              : lodm_pkg::CONF_CONNECTED;
            st.sense_neg_confidence = neg_off ? lodm_pkg::CONF_DEFINITE_OFF
                                              : lodm_pkg::CONF_CONNECTED;
         end
         status_q.insert(status_q.size(), st);
      endfunction

      function void check_field(string name, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("status mismatch on %s: expected %0h, got %0h", name, want, got);
         end
      endfunction

      // Compare one accepted status item with the oldest expectation
      function void check_status(logic [RSP_DATA_W-1:0] data);
         lodm_pkg::result_type want, got;
         got = lodm_pkg::result_type'(data[STATUS_W-1:0]);
         if (status_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("status item %h arrived with no sample outstanding", data);
            return;
         end
         want = status_q.pop_front();
         check_field("active", 8'(want.active), 8'(got.active));
         check_field("debounced_flags", 8'(want.debounced_flags),
                     8'(got.debounced_flags));
         check_field("pos_sense_off", 8'(want.pos_sense_off), 8'(got.pos_sense_off));
         check_field("neg_sense_off", 8'(want.neg_sense_off), 8'(got.neg_sense_off));
         check_field("drive_leads_invalid", 8'(want.drive_leads_invalid),
                     8'(got.drive_leads_invalid));
         check_field("compliance_warning", 8'(want.compliance_warning),
                     8'(got.compliance_warning));
         check_field("off_mask", 8'(want.off_mask), 8'(got.off_mask));
         check_field("possible_off_mask", 8'(want.possible_off_mask),
                     8'(got.possible_off_mask));
         check_field("drive_pos_confidence", 8'(want.drive_pos_confidence),
                     8'(got.drive_pos_confidence));
         check_field("sense_pos_confidence", 8'(want.sense_pos_confidence),
                     8'(got.sense_pos_confidence));
         check_field("sense_neg_confidence", 8'(want.sense_neg_confidence),
                     8'(got.sense_neg_confidence));
         check_field("drive_neg_confidence", 8'(want.drive_neg_confidence),
                     8'(got.drive_neg_confidence));
         check_field("unused bits", 8'(0), 8'(data[RSP_DATA_W-1:STATUS_W]));
      endfunction
   endclass

   logic                  clock              = 1'b0;
   logic                  reset              = 1'b1;
   logic                  csr_we             = 1'b0;
   logic [CNT_W-1:0]      csr_debounce_count = '0;
   logic                  req_tvalid         = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata          = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready         = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   debounce_tracker_type  tracker;
   logic [NUM_FLAGS-1:0]  held_flags  = '0;
   int unsigned           burst_left  = 0;
   int unsigned           cycle_count = 0;
   int unsigned           mode_cycles = 0;
   ready_pattern_type     ready_mode  = READY_ALWAYS;

   lead_off_debounce_monitor DUT (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_debounce_count (csr_debounce_count),
      .req_tvalid         (req_tvalid),
      .req_tready         (req_tready),
      .req_tdata          (req_tdata),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_tready         (rsp_tready),
      .rsp_tdata          (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Handshake monitor and receiver stall pattern
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            tracker.note_sample(lodm_pkg::sample_type'(req_tdata[SAMPLE_W-1:0]));
         if (rsp_tvalid && rsp_tready)
            tracker.check_status(rsp_tdata);
      end
      if (mode_cycles == 0) begin
         ready_mode  <= ready_pattern_type'($urandom_range(READY_ALWAYS, READY_PULSED));
         mode_cycles <= $urandom_range(20, 80);
      end else begin
         mode_cycles <= mode_cycles - 1;
      end
      case (ready_mode)
         READY_ALWAYS: rsp_tready <= 1'b1;
         READY_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
         READY_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
         default:      rsp_tready <= (mode_cycles % 7 == 0);
      endcase
   end

   // One sample, then a random gap once the current burst runs out
   task automatic send_sample(input logic [NUM_FLAGS-1:0] flags, input logic enable,
                              input logic meas);
      lodm_pkg::sample_type s;
      s.raw_flags      = flags;
      s.monitor_enable = enable;
      s.measuring      = meas;
      req_tdata  <= REQ_DATA_W'(s);
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 10);
      end else begin
         burst_left--;
      end
   endtask

   // Same flags held on consecutive active samples
   task automatic send_run(input logic [NUM_FLAGS-1:0] flags, input int unsigned reps);
      held_flags = flags;
      repeat (reps) send_sample(flags, 1'b1, 1'b1);
   endtask

   // Slowly changing flags on active samples, with some noise samples mixed in
   task automatic run_phase(input int unsigned n, input int unsigned flip_odds,
                            input int unsigned noise_pct);
      logic [NUM_FLAGS-1:0] flags;
      logic                 enable, meas;
      int                   i;
      repeat (n) begin
         for (i = 0; i < NUM_FLAGS; i++)
            if ($urandom_range(1, flip_odds) == 1) held_flags[i] = ~held_flags[i];
         flags  = held_flags;
         enable = 1'b1;
         meas   = 1'b1;
         if ($urandom_range(1, 100) <= noise_pct) begin
            flags  = NUM_FLAGS'($urandom_range(0, (1 << NUM_FLAGS) - 1));
            enable = 1'($urandom_range(0, 1));
            meas   = 1'($urandom_range(0, 1));
         end
         send_sample(flags, enable, meas);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.status_q.size() != 0) @(posedge clock);
   endtask

   // Register write with nothing in flight
   task automatic set_debounce(input logic [CNT_W-1:0] value);
      wait_drained();
      repeat (3) @(posedge clock);
      csr_debounce_count <= value;
      csr_we             <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.set_count(value);
   endtask

   initial begin
      tracker = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // inactive samples in every enable/measuring combination
      send_sample(ALL_FLAGS, 1'b0, 1'b0);
      send_sample(ALL_FLAGS, 1'b1, 1'b0);
      send_sample(ALL_FLAGS, 1'b0, 1'b1);
      send_run('0, 1);
      // one sense flag, then AC lead-off alone, at the reset count
      send_run(NUM_FLAGS'(1) << lodm_pkg::FLAG_POS_OVER, 3);
      send_run(NUM_FLAGS'(1) << lodm_pkg::FLAG_LVL_OVER, 3);
      // drive fault without AC lead-off gives the compliance warning
      send_run((NUM_FLAGS'(1) << lodm_pkg::FLAG_DRIVE) |
               (NUM_FLAGS'(1) << lodm_pkg::FLAG_NEG_UNDER), 3);
      // AC lead-off with sense fault and drive fault: leads invalid
      send_run((NUM_FLAGS'(1) << lodm_pkg::FLAG_LVL_UNDER) |
               (NUM_FLAGS'(1) << lodm_pkg::FLAG_DRIVE) |
               (NUM_FLAGS'(1) << lodm_pkg::FLAG_POS_UNDER), 3);
      send_run(ALL_FLAGS, 3);
      // drop out of measuring mid-run; counters must restart
      send_sample(ALL_FLAGS, 1'b1, 1'b0);
      send_run((NUM_FLAGS'(1) << lodm_pkg::FLAG_LVL_OVER) |
               (NUM_FLAGS'(1) << lodm_pkg::FLAG_NEG_OVER), 3);

      set_debounce(8'd1);
      run_phase(30, 3, 10);
      // zero count: every flag reads debounced while active
      set_debounce(8'd0);
      run_phase(20, 2, 15);
      // longest count, held long enough to saturate
      set_debounce(8'd255);
      held_flags = ALL_FLAGS;
      run_phase(260, 1000, 0);
      // count lowered below the counters' values
      set_debounce(8'd2);
      run_phase(30, 8, 5);
      set_debounce(8'($urandom_range(4, 12)));
      run_phase(35, 10, 5);
      set_debounce(lodm_pkg::DEBOUNCE_RESET);
      run_phase(25, 5, 8);
      set_debounce(8'($urandom_range(1, 6)));
      run_phase(27, 4, 10);

      wait_drained();
      repeat (10) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.status_q.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
